[src/dtm_pkg.sv]
// dtm_pkg: shared types, codes and sizes for the deadline timer manager
// depends on nothing; used by every file in src
package dtm_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int TIME_BITS  = 48;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int MAX_OUT    = 32;
  localparam int EMIT_W     = $clog2(MAX_OUT + 1);
  localparam int ORD_W      = 32;
  localparam int REM_W      = 48;
  localparam int WIDE_W     = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;

  // request kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_NEXT   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ACK     = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_EXPIRED = 3'd2;
  localparam logic [2:0] ST_NEXT    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [31:0] duration;
    logic [47:0] now;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_res;
    logic [47:0] remaining;
    logic        last;
  } out_t;

  // running best candidate of a scan
  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     idx;
    logic [TIME_BITS-1:0] dl;
    logic [ORD_W-1:0]     ord;
  } best_t;

endpackage

[src/dtm_store.sv]
// dtm_store: deadline and arm order memory, one write and one registered read port
// depends on dtm_pkg
module dtm_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [dtm_pkg::IDX_W-1:0]     wr_addr,
  input  logic [dtm_pkg::TIME_BITS-1:0] wr_dl,
  input  logic [dtm_pkg::ORD_W-1:0]     wr_ord,
  input  logic [dtm_pkg::IDX_W-1:0]     rd_addr,
  output logic [dtm_pkg::TIME_BITS-1:0] rd_dl,
  output logic [dtm_pkg::ORD_W-1:0]     rd_ord
);

  logic [dtm_pkg::TIME_BITS-1:0] dl_mem  [dtm_pkg::NUM_TIMERS];
  logic [dtm_pkg::ORD_W-1:0]     ord_mem [dtm_pkg::NUM_TIMERS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr]  <= wr_dl;
      ord_mem[wr_addr] <= wr_ord;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_dl  <= dl_mem[rd_addr];
    rd_ord <= ord_mem[rd_addr];
  end

endmodule

[src/dtm_cmp.sv]
// dtm_cmp: shared compare unit keeping the earliest armed slot seen in a scan
// depends on dtm_pkg
module dtm_cmp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          take,
  input  logic [dtm_pkg::IDX_W-1:0]     idx,
  input  logic [dtm_pkg::TIME_BITS-1:0] dl,
  input  logic [dtm_pkg::ORD_W-1:0]     ord,
  output dtm_pkg::best_t                best
);

  dtm_pkg::best_t   best_r;
  logic             earlier;
  logic [dtm_pkg::ORD_W-1:0] ord_diff;

  // earlier deadline wins, ties go to the older arm order (wrapping)
  always_comb begin
    ord_diff = ord - best_r.ord;
    if (dl != best_r.dl) begin
      earlier = dl < best_r.dl;
    end else begin
      earlier = ord_diff[dtm_pkg::ORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      best_r.valid <= 1'b0;
    end else if (take && (!best_r.valid || earlier)) begin
      best_r.valid <= 1'b1;
      best_r.idx   <= idx;
      best_r.dl    <= dl;
      best_r.ord   <= ord;
    end
  end

  assign best = best_r;

endmodule

[src/deadline_timer_manager.sv]
// deadline_timer_manager: top level, request sequencer, armed bits and result register
// depends on dtm_pkg, dtm_store, dtm_cmp
//
// Start and stop requests offer their result in the cycle after accept. Expire and next
// requests scan every slot through one compare unit, one slot per cycle, a pace set by
// the memory read port; an expire request runs one scan per expired slot plus a final
// one, up to 32 results.
// One request is handled at a time; in_ready is low until its last beat is taken.
module deadline_timer_manager (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtm_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dtm_pkg::out_t  out_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  localparam int TB = dtm_pkg::TIME_BITS;
  localparam int WW = dtm_pkg::WIDE_W;

  logic [1:0]                      state_r;
  logic [dtm_pkg::NUM_TIMERS-1:0]  armed_r;
  logic [dtm_pkg::ORD_W-1:0]       order_r;
  logic [1:0]                      kind_r;
  logic [TB-1:0]                   now_r;
  logic [dtm_pkg::CNT_W-1:0]       scan_r;
  logic                            pv_r;
  logic [dtm_pkg::IDX_W-1:0]       pidx_r;
  logic [dtm_pkg::EMIT_W-1:0]      emit_r;
  logic                            pend_r;
  logic [dtm_pkg::IDX_W-1:0]       pend_idx_r;
  logic                            out_valid_r;
  dtm_pkg::out_t                   out_r;

  logic [WW-1:0]                   now_w;
  logic [TB-1:0]                   in_now;
  logic [TB:0]                     sum;
  logic [TB-1:0]                   dl_sat;
  logic                            bad_slot;
  logic [dtm_pkg::IDX_W-1:0]       in_idx;
  logic                            wr_en;
  logic                            issue;
  logic                            scan_clear;
  logic [dtm_pkg::TIME_BITS-1:0]   rd_dl;
  logic [dtm_pkg::ORD_W-1:0]       rd_ord;
  dtm_pkg::best_t                  best;
  logic                            due;
  logic [TB-1:0]                   diff;
  logic [WW-1:0]                   diff_w;
  logic [dtm_pkg::REM_W-1:0]       rem;

  // input decode and saturating deadline
  always_comb begin
    now_w    = WW'(in_data.now);
    in_now   = now_w[TB-1:0];
    sum      = {1'b0, in_now} + (TB+1)'(in_data.duration);
    dl_sat   = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
    bad_slot = 32'(in_data.slot) >= 32'(dtm_pkg::NUM_TIMERS);
    in_idx   = dtm_pkg::IDX_W'(in_data.slot);
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign wr_en = in_valid && in_ready && (in_data.kind == dtm_pkg::KIND_START) &&
                 (in_data.duration != '0) && !bad_slot;
  assign issue = (state_r == S_SCAN) && (scan_r < dtm_pkg::CNT_W'(dtm_pkg::NUM_TIMERS));
  assign scan_clear = (state_r != S_SCAN);

  dtm_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_idx),
    .wr_dl   (dl_sat),
    .wr_ord  (order_r),
    .rd_addr (scan_r[dtm_pkg::IDX_W-1:0]),
    .rd_dl   (rd_dl),
    .rd_ord  (rd_ord)
  );

  dtm_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (scan_clear),
    .take  (pv_r && armed_r[pidx_r]),
    .idx   (pidx_r),
    .dl    (rd_dl),
    .ord   (rd_ord),
    .best  (best)
  );

  // scan outcome
  always_comb begin
    due    = best.valid && (best.dl <= now_r) &&
             (emit_r < dtm_pkg::EMIT_W'(dtm_pkg::MAX_OUT));
    diff   = (best.dl > now_r) ? (best.dl - now_r) : '0;
    diff_w = WW'(diff);
    rem    = (diff_w > WW'({dtm_pkg::REM_W{1'b1}})) ? {dtm_pkg::REM_W{1'b1}}
                                                     : dtm_pkg::REM_W'(diff_w);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= '0;
      order_r     <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      pend_r      <= 1'b0;
      emit_r      <= '0;
      scan_r      <= '0;
    end else begin
      pv_r   <= issue;
      pidx_r <= scan_r[dtm_pkg::IDX_W-1:0];
      if (issue) begin
        scan_r <= scan_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            kind_r <= in_data.kind;
            now_r  <= in_now;
            pend_r <= 1'b0;
            emit_r <= '0;
            scan_r <= '0;
            out_r.slot_res  <= in_data.slot;
            out_r.remaining <= '0;
            out_r.last      <= 1'b1;
            case (in_data.kind)
              dtm_pkg::KIND_START: begin
                state_r     <= S_OUT;
                out_valid_r <= 1'b1;
                if (in_data.duration == '0 || bad_slot) begin
                  out_r.status <= dtm_pkg::ST_REJECT;
                end else begin
                  out_r.status    <= dtm_pkg::ST_ACK;
                  armed_r[in_idx] <= 1'b1;
                  order_r         <= order_r + 1'b1;
                end
              end
              dtm_pkg::KIND_STOP: begin
                state_r     <= S_OUT;
                out_valid_r <= 1'b1;
                if (bad_slot) begin
                  out_r.status <= dtm_pkg::ST_REJECT;
                end else begin
                  out_r.status    <= dtm_pkg::ST_ACK;
                  armed_r[in_idx] <= 1'b0;
                end
              end
              default: begin
                state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!issue && !pv_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          out_r.remaining <= '0;
          out_r.slot_res  <= '0;
          if (kind_r == dtm_pkg::KIND_NEXT) begin
            out_r.last  <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
            if (best.valid) begin
              out_r.status    <= dtm_pkg::ST_NEXT;
              out_r.remaining <= rem;
            end else begin
              out_r.status <= dtm_pkg::ST_NONE;
            end
          end else if (due) begin
            // disarm the new earliest and hold it until the next scan tells if it is last
            armed_r[best.idx] <= 1'b0;
            emit_r            <= emit_r + 1'b1;
            pend_r            <= 1'b1;
            pend_idx_r        <= best.idx;
            scan_r            <= '0;
            if (pend_r) begin
              out_r.status   <= dtm_pkg::ST_EXPIRED;
              out_r.slot_res <= 5'(pend_idx_r);
              out_r.last     <= 1'b0;
              out_valid_r    <= 1'b1;
              state_r        <= S_OUT;
            end else begin
              state_r <= S_SCAN;
            end
          end else begin
            out_r.last  <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
            if (pend_r) begin
              out_r.status   <= dtm_pkg::ST_EXPIRED;
              out_r.slot_res <= 5'(pend_idx_r);
            end else begin
              out_r.status <= dtm_pkg::ST_NONE;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= out_r.last ? S_IDLE : S_SCAN;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // a result beat is only offered from the output state
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (state_r == S_OUT))
    else $error("result offered outside output state");

  // no new request while a result waits
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // expire never emits more than the result limit
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= dtm_pkg::EMIT_W'(dtm_pkg::MAX_OUT))
    else $error("emit count beyond limit");

  // a non-final expired beat is always followed by another scan
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=> (state_r == S_SCAN))
    else $error("expire sequence lost its next scan");

endmodule
